/* rtl/core/pleu_pkg.sv */
// Package for the positional list engine: action and status codes.
// No dependencies; the top level and the testbench import it.
`timescale 1ns / 1ps
package pleu_pkg;

  localparam logic [2:0] ACT_GET    = 3'd0;
  localparam logic [2:0] ACT_LOCATE = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_POS   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

endpackage

/* rtl/core/pleu_req_if.sv */
// Request channel of the positional list engine: valid, ready and one action.
// Uses no package.
`timescale 1ns / 1ps
interface pleu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  position;
  logic [31:0] elem_x;
  logic [31:0] elem_y;

  modport source (output valid, action, position, elem_x, elem_y, input ready);
  modport sink (input valid, action, position, elem_x, elem_y, output ready);
endinterface

/* rtl/core/pleu_rsp_if.sv */
// Response channel of the positional list engine: valid, ready and one result.
// Uses no package.
`timescale 1ns / 1ps
interface pleu_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  found_position;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [6:0]  count_now;
  logic        is_empty;

  modport source (output valid, status, found_position, out_x, out_y, count_now, is_empty,
                  input ready);
  modport sink (input valid, status, found_position, out_x, out_y, count_now, is_empty,
                output ready);
endinterface

/* rtl/core/positional_list_engine_unit.sv */
// Top level of the positional list engine: an ordered list of pairs kept in one memory.
// Depends on pleu_pkg, pleu_req_if and pleu_rsp_if.
//
//   channel  modport  transfer carries
//   in_ch    sink     action, position, elem_x, elem_y
//   out_ch   source   status, found_position, out_x, out_y, count_now, is_empty
//
// One action is in work at a time; every memory access uses the one read port and the one write port.
// Get reads one entry; clear and failed checks go straight to the final state; locate scans from the first entry.
// Insert shifts entries from the end up to the position, then writes the pair; delete shifts later entries down.
// Reset empties the list at once; no clearing pass is run over the memory.
// A stalled response holds the next result in the final state until the stalled one is transferred.
`timescale 1ns / 1ps
module positional_list_engine_unit
  import pleu_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  pleu_req_if.sink   in_ch,
  pleu_rsp_if.source out_ch
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CNTW > 8) ? CNTW : 8) + 1;
  localparam int CW   = COORD_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_GET, S_DEL_CAP, S_DEL_SH, S_INS_SH, S_INS_WR, S_SCAN, S_FIN
  } state_t;

  state_t state;
  logic [CNTW-1:0] count;
  logic [CMPW-1:0] pos_q;
  logic [CW-1:0] x_q, y_q;
  logic [AW-1:0] rd_idx;
  logic [2:0] res_status;
  logic [CNTW-1:0] res_found;
  logic [CW-1:0] res_x, res_y;

  logic [2*CW-1:0] mem [CAPACITY];
  logic [2*CW-1:0] rd_data;
  logic mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [2*CW-1:0] mem_wd;

  logic accept;
  logic [CMPW-1:0] in_pos, cnt_ext, idx_ext;
  logic [CNTW-1:0] idx_inc;
  logic signed [CW-1:0] sx, sy;

  state_t idle_next;
  logic [2:0] idle_status;
  logic [AW-1:0] idle_idx;

  assign in_ch.ready = (state == S_IDLE);
  assign accept  = in_ch.valid && in_ch.ready;
  assign in_pos  = CMPW'(in_ch.position);
  assign cnt_ext = CMPW'(count);
  assign idx_ext = CMPW'(rd_idx);
  assign idx_inc = CNTW'(rd_idx) + CNTW'(1);
  assign sx = res_x;
  assign sy = res_y;

  always_comb begin
    idle_next   = S_FIN;
    idle_status = ST_OK;
    idle_idx    = '0;
    unique case (in_ch.action)
      ACT_GET, ACT_DELETE: begin
        idle_idx = AW'(in_pos - CMPW'(1));
        if (count == '0) begin
          idle_status = ST_EMPTY;
        end else if (in_pos == '0 || in_pos > cnt_ext) begin
          idle_status = ST_BAD_POS;
        end else begin
          idle_next = (in_ch.action == ACT_GET) ? S_GET : S_DEL_CAP;
        end
      end
      ACT_LOCATE: begin
        if (count == '0) begin
          idle_status = ST_EMPTY;
        end else begin
          idle_next = S_SCAN;
        end
      end
      ACT_INSERT: begin
        idle_idx = AW'(cnt_ext - CMPW'(1));
        if (in_pos == '0 || in_pos > cnt_ext + CMPW'(1)) begin
          idle_status = ST_BAD_POS;
        end else if (cnt_ext >= CMPW'(CAPACITY)) begin
          idle_status = ST_FULL;
        end else if (in_pos <= cnt_ext) begin
          idle_next = S_INS_SH;
        end else begin
          idle_next = S_INS_WR;
        end
      end
      default: idle_next = S_FIN;
    endcase
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.action)
            ACT_GET, ACT_DELETE: begin
              mem_re = 1'b1;
              mem_ra = AW'(in_pos - CMPW'(1));
            end
            ACT_LOCATE: mem_re = 1'b1;
            ACT_INSERT: begin
              mem_re = 1'b1;
              mem_ra = AW'(cnt_ext - CMPW'(1));
            end
            default: mem_re = 1'b0;
          endcase
        end
      end
      S_DEL_CAP, S_SCAN: begin
        mem_re = 1'b1;
        mem_ra = AW'(idx_inc);
      end
      S_DEL_SH: begin
        mem_we = 1'b1;
        mem_wa = AW'(idx_ext - CMPW'(1));
        mem_re = 1'b1;
        mem_ra = AW'(idx_inc);
      end
      S_INS_SH: begin
        mem_we = 1'b1;
        mem_wa = AW'(idx_inc);
        mem_re = 1'b1;
        mem_ra = AW'(idx_ext - CMPW'(1));
      end
      S_INS_WR: begin
        mem_we = 1'b1;
        mem_wa = AW'(pos_q - CMPW'(1));
        mem_wd = {x_q, y_q};
      end
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_FIN) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos_q      <= in_pos;
            x_q        <= in_ch.elem_x[CW-1:0];
            y_q        <= in_ch.elem_y[CW-1:0];
            res_status <= idle_status;
            res_found  <= '0;
            res_x      <= '0;
            res_y      <= '0;
            rd_idx     <= idle_idx;
            state      <= idle_next;
            if (in_ch.action == ACT_CLEAR) begin
              count <= '0;
            end
          end
        end
        S_GET: begin
          res_x <= rd_data[2*CW-1:CW];
          res_y <= rd_data[CW-1:0];
          state <= S_FIN;
        end
        S_DEL_CAP: begin
          res_x <= rd_data[2*CW-1:CW];
          res_y <= rd_data[CW-1:0];
          if (idx_inc < count) begin
            rd_idx <= AW'(idx_inc);
            state  <= S_DEL_SH;
          end else begin
            count <= count - CNTW'(1);
            state <= S_FIN;
          end
        end
        S_DEL_SH: begin
          if (idx_inc < count) begin
            rd_idx <= AW'(idx_inc);
          end else begin
            count <= count - CNTW'(1);
            state <= S_FIN;
          end
        end
        S_INS_SH: begin
          if (idx_ext >= pos_q) begin
            rd_idx <= rd_idx - AW'(1);
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          count <= count + CNTW'(1);
          state <= S_FIN;
        end
        S_SCAN: begin
          if (rd_data == {x_q, y_q}) begin
            res_found <= idx_inc;
            state     <= S_FIN;
          end else if (idx_inc < count) begin
            rd_idx <= AW'(idx_inc);
          end else begin
            res_status <= ST_NOT_FOUND;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid          <= 1'b1;
            out_ch.status         <= res_status;
            out_ch.found_position <= 7'(res_found);
            out_ch.out_x          <= 32'(sx);
            out_ch.out_y          <= 32'(sy);
            out_ch.count_now      <= 7'(count);
            out_ch.is_empty       <= (count == '0);
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CNTW'(CAPACITY) >= count)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.count_now == 7'd0)))
    else $error("empty flag disagrees with count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.found_position != 7'd0) |-> (out_ch.status == ST_OK))
    else $error("found position with failing status");

endmodule

/* tb/sv/positional_list_engine_unit_test.sv */
// Self-checking testbench for the positional list engine: directed table, then random traffic.
// Responses are checked against a table row's result if given, else a list model in this file.
// Depends on pleu_pkg, pleu_req_if, pleu_rsp_if and positional_list_engine_unit.
`timescale 1ns / 1ps
module positional_list_engine_unit_test;
  import pleu_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  position;
    logic [31:0] elem_x;
    logic [31:0] elem_y;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  found_position;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [6:0]  count_now;
    logic        is_empty;
  } rsp_t;

  typedef struct {
    req_t req;
    bit   has_rsp;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pleu_req_if in_ch ();
  pleu_rsp_if out_ch ();

  positional_list_engine_unit #(.CAPACITY(CAP), .COORD_WIDTH(32)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] list_pairs [CAP];
  int          list_len = 0;
  rsp_t        pending_rsp [$];
  bit          typed_has_q [$];
  rsp_t        typed_exp_q [$];
  bit          typed_now = 1'b0;
  rsp_t        typed_val = '0;
  int          mismatches = 0;
  int          sent = 0;
  int          received = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_off = 1'b0;
  row_t        dir_rows [$];

  function automatic rsp_t list_apply(req_t r);
    rsp_t o;
    int   p;
    o = '0;
    p = r.position;
    case (r.action)
      ACT_GET, ACT_DELETE: begin
        if (list_len == 0) begin
          o.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          o.status = ST_BAD_POS;
        end else begin
          o.status = ST_OK;
          {o.out_x, o.out_y} = list_pairs[p-1];
          if (r.action == ACT_DELETE) begin
            for (int k = p; k < list_len; k++) list_pairs[k-1] = list_pairs[k];
            list_len--;
          end
        end
      end
      ACT_LOCATE: begin
        if (list_len == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.status = ST_NOT_FOUND;
          for (int k = 0; k < list_len; k++) begin
            if (list_pairs[k] == {r.elem_x, r.elem_y}) begin
              o.status = ST_OK;
              o.found_position = 7'(k + 1);
              break;
            end
          end
        end
      end
      ACT_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          o.status = ST_BAD_POS;
        end else if (list_len >= CAP) begin
          o.status = ST_FULL;
        end else begin
          for (int k = list_len; k >= p; k--) list_pairs[k] = list_pairs[k-1];
          list_pairs[p-1] = {r.elem_x, r.elem_y};
          list_len++;
        end
      end
      ACT_CLEAR: list_len = 0;
      default: ;
    endcase
    o.count_now = 7'(list_len);
    o.is_empty = (list_len == 0);
    return o;
  endfunction

  function automatic req_t mk(logic [2:0] a, logic [7:0] p, logic [31:0] x, logic [31:0] y);
    req_t r;
    r.action = a;
    r.position = p;
    r.elem_x = x;
    r.elem_y = y;
    return r;
  endfunction

  function automatic rsp_t rs(logic [2:0] s, logic [6:0] c);
    rsp_t o;
    o = '0;
    o.status = s;
    o.count_now = c;
    o.is_empty = (c == 0);
    return o;
  endfunction

  function automatic void add_row(req_t r, bit h, rsp_t o);
    row_t w;
    w.req = r;
    w.has_rsp = h;
    w.rsp = o;
    dir_rows.push_back(w);
  endfunction

  task automatic send_item(req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.action, in_ch.position, in_ch.elem_x, in_ch.elem_y} <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      pending_rsp.push_back(list_apply({in_ch.action, in_ch.position, in_ch.elem_x,
                                        in_ch.elem_y}));
      typed_has_q.push_back(typed_now);
      typed_exp_q.push_back(typed_val);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      rsp_t got;
      rsp_t exp;
      rsp_t typed;
      bit   has;
      got = {out_ch.status, out_ch.found_position, out_ch.out_x, out_ch.out_y,
             out_ch.count_now, out_ch.is_empty};
      received++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %h", got);
      end else begin
        exp = pending_rsp.pop_front();
        has = typed_has_q.pop_front();
        typed = typed_exp_q.pop_front();
        if (has) exp = typed;
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: st %0d/%0d fp %0d/%0d x %h/%h y %h/%h n %0d/%0d e %b/%b",
                     exp.status, got.status, exp.found_position, got.found_position,
                     exp.out_x, got.out_x, exp.out_y, got.out_y, exp.count_now,
                     got.count_now, exp.is_empty, got.is_empty);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_GET;
    in_ch.position = '0;
    in_ch.elem_x = '0;
    in_ch.elem_y = '0;
    out_ch.ready = 1'b0;
  end

  function automatic req_t rand_req();
    req_t r;
    int   w;
    r.elem_x = $urandom();
    r.elem_y = $urandom();
    if ($urandom_range(3) == 0 && list_len > 0) begin
      {r.elem_x, r.elem_y} = list_pairs[$urandom_range(list_len - 1)];
    end
    w = $urandom_range(99);
    if (w < 35) r.action = ACT_INSERT;
    else if (w < 55) r.action = ACT_GET;
    else if (w < 75) r.action = ACT_LOCATE;
    else if (w < 95) r.action = ACT_DELETE;
    else if (w < 97) r.action = ACT_CLEAR;
    else r.action = 3'($urandom_range(7));
    if ($urandom_range(9) == 0) r.position = 8'($urandom());
    else r.position = 8'($urandom_range(list_len + 1));
    return r;
  endfunction

  task automatic run_phase(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) send_item(rand_req());
  endtask

  initial begin
    rsp_t nil;
    int   waited;
    nil = '0;
    add_row(mk(ACT_GET, 8'd1, '0, '0), 1, rs(ST_EMPTY, 0));
    add_row(mk(ACT_LOCATE, 8'd0, '0, '0), 1, rs(ST_EMPTY, 0));
    add_row(mk(ACT_DELETE, 8'd1, '0, '0), 1, rs(ST_EMPTY, 0));
    add_row(mk(ACT_INSERT, 8'd0, '0, '0), 1, rs(ST_BAD_POS, 0));
    add_row(mk(ACT_INSERT, 8'd2, '0, '0), 1, rs(ST_BAD_POS, 0));
    add_row(mk(ACT_INSERT, 8'd1, 32'h7fffffff, 32'h80000000), 1, rs(ST_OK, 1));
    add_row(mk(ACT_INSERT, 8'd1, 32'h80000000, 32'h7fffffff), 1, rs(ST_OK, 2));
    add_row(mk(ACT_INSERT, 8'd3, 32'hffffffff, 32'h0), 1, rs(ST_OK, 3));
    add_row(mk(ACT_INSERT, 8'd2, 32'h0, 32'hffffffff), 0, nil);
    add_row(mk(ACT_GET, 8'd0, '0, '0), 1, rs(ST_BAD_POS, 4));
    add_row(mk(ACT_GET, 8'd255, '0, '0), 1, rs(ST_BAD_POS, 4));
    add_row(mk(ACT_GET, 8'd1, '0, '0), 0, nil);
    add_row(mk(ACT_GET, 8'd4, '0, '0), 0, nil);
    add_row(mk(ACT_LOCATE, 8'd0, 32'hffffffff, 32'h0), 0, nil);
    add_row(mk(ACT_LOCATE, 8'd0, 32'h12345678, 32'h0), 1, rs(ST_NOT_FOUND, 4));
    add_row(mk(ACT_DELETE, 8'd5, '0, '0), 1, rs(ST_BAD_POS, 4));
    add_row(mk(ACT_DELETE, 8'd2, '0, '0), 0, nil);
    add_row(mk(3'd5, 8'd1, '0, '0), 1, rs(ST_OK, 3));
    add_row(mk(3'd7, 8'd255, 32'hffffffff, 32'hffffffff), 1, rs(ST_OK, 3));
    add_row(mk(ACT_CLEAR, 8'd0, '0, '0), 1, rs(ST_OK, 0));
    add_row(mk(ACT_GET, 8'd1, '0, '0), 1, rs(ST_EMPTY, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 10;
    recv_idle = 10;
    foreach (dir_rows[i]) begin
      typed_now = dir_rows[i].has_rsp;
      typed_val = dir_rows[i].rsp;
      send_item(dir_rows[i].req);
    end
    typed_now = 1'b0;
    drop_valid();
    while (pending_rsp.size() != 0) @(negedge clk);

    // Fill the list to capacity and keep inserting to reach the full status.
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < CAP + 4; i++) begin
      send_item(mk(ACT_INSERT, 8'($urandom_range(list_len) + 1), $urandom(), $urandom()));
    end
    for (int i = 0; i < 20; i++) send_item(rand_req());

    run_phase(500, 10, 82);
    run_phase(500, 82, 10);

    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      run_phase(60, 0, 0);
    join
    run_phase(400, 0, 0);
    drop_valid();

    waited = 0;
    while (pending_rsp.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    $display("Run covered %0d requests and %0d responses across directed, idle and stall phases.",
             sent, received);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* positional_list_engine_unit.f */
rtl/core/pleu_pkg.sv
rtl/core/pleu_req_if.sv
rtl/core/pleu_rsp_if.sv
rtl/core/positional_list_engine_unit.sv
tb/sv/positional_list_engine_unit_test.sv
